// ===== design/dtc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtc_pkg: shared definitions for the double threshold classifier
// Opcodes, register indexes, edge codes, queue sizing and shared types.
// ----------------------------------------------------------------------------
package dtc_pkg;

   localparam int PIXEL_BITS_DEF = 8;
   localparam int RATIO_BITS     = 17;
   localparam int FRAC_BITS      = 16;
   localparam int EDGE_BITS      = 8;
   localparam int OPCODE_BITS    = 2;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [RATIO_BITS-1:0] RATIO_HIGH_RESET = 17'd65536;
   localparam logic [RATIO_BITS-1:0] RATIO_LOW_RESET  = 17'd32768;

   localparam logic [OPCODE_BITS-1:0] OP_CLEAR    = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_MEASURE  = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_CLASSIFY = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATIO_HIGH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATIO_LOW  = 2'd1;

   localparam logic [EDGE_BITS-1:0] EDGE_STRONG = 8'd255;
   localparam logic [EDGE_BITS-1:0] EDGE_WEAK   = 8'd25;
   localparam logic [EDGE_BITS-1:0] EDGE_NONE   = 8'd0;

   // classify queue between front and back
   localparam int Q_DEPTH      = 2;
   localparam int Q_PTR_BITS   = 1;
   localparam int Q_COUNT_BITS = 2;

   typedef enum logic {
      BK_IDLE,
      BK_CMP
   } bk_state_type;

   typedef struct packed {
      logic busy;   // back holds a high-threshold product
      logic pop;    // back takes the queue head this cycle
   } bk_status_type;

endpackage

// ===== design/double_threshold_classifier.sv =====
// Path: a classify item moves from the queue to the multiply register, then
//   through the low product and compare into the result register.
// Throughput: 1 item per cycle while results are taken; one item's high multiply
//   overlaps the previous item's low multiply; a stalled result fills the queue.
// Reset: synchronous, active high; frame maximum 0, ratio_high 1.0, ratio_low 0.5,
//   queue empty, no result pending.
// ----------------------------------------------------------------------------
// double_threshold_classifier: two-pass double threshold for edge detection
// Front keeps the frame maximum and queues classify items; back computes
// the thresholds exactly in fixed point and emits 255 / 25 / 0.
// ----------------------------------------------------------------------------
module double_threshold_classifier #(
   parameter int PIXEL_BITS = dtc_pkg::PIXEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [dtc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dtc_pkg::RATIO_BITS-1:0]      csr_wr_data,
   // input items
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dtc_pkg::OPCODE_BITS-1:0]     req_opcode,
   input  logic [PIXEL_BITS-1:0]               req_pixel_value,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dtc_pkg::EDGE_BITS-1:0]       rsp_edge_value
);

   logic [dtc_pkg::RATIO_BITS-1:0] ratio_high_ff;
   logic [dtc_pkg::RATIO_BITS-1:0] ratio_high_in;
   logic [dtc_pkg::RATIO_BITS-1:0] ratio_low_ff;
   logic [dtc_pkg::RATIO_BITS-1:0] ratio_low_in;

   logic                           q_push;
   logic [2*PIXEL_BITS-1:0]        q_push_data;
   logic                           q_pop;
   logic [2*PIXEL_BITS-1:0]        q_head;
   logic                           q_full;
   logic                           q_empty;
   dtc_pkg::bk_status_type         bk_status;

   // Ratio registers. Writes to unused indexes are dropped.
   always_comb begin
      ratio_high_in = ratio_high_ff;
      ratio_low_in  = ratio_low_ff;
      if (csr_wr_en) begin
         case (csr_index)
            dtc_pkg::CSR_RATIO_HIGH: ratio_high_in = csr_wr_data;
            dtc_pkg::CSR_RATIO_LOW:  ratio_low_in  = csr_wr_data;
            default: begin
               ratio_high_in = ratio_high_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_high_ff <= dtc_pkg::RATIO_HIGH_RESET;
         ratio_low_ff  <= dtc_pkg::RATIO_LOW_RESET;
      end else begin
         ratio_high_ff <= ratio_high_in;
         ratio_low_ff  <= ratio_low_in;
      end
   end

   // Front: clear/measure act at once on the maximum; classify items carry
   // a snapshot of the maximum into the queue, so later items may update it.
   dtc_front #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_pixel_value (req_pixel_value),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_push_data     (q_push_data)
   );

   dtc_queue #(
      .WIDTH (2 * PIXEL_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back: one multiply in each of its two stages, result register
   // decouples rsp_ready.
   dtc_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .ratio_high     (ratio_high_ff),
      .ratio_low      (ratio_low_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_value (rsp_edge_value),
      .status         (bk_status)
   );

   // queue never overflows
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("classify queue push while full");

   // queue never underflows
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("classify queue pop while empty");

   // a new result only follows a compare cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(bk_status.busy))
      else $error("result appeared without a compare cycle");

   // results are only the edge codes: strong, weak or none
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_edge_value == dtc_pkg::EDGE_STRONG ||
                     rsp_edge_value == dtc_pkg::EDGE_WEAK ||
                     rsp_edge_value == dtc_pkg::EDGE_NONE))
      else $error("result is not an edge code");

endmodule

// ===== design/dtc_front.sv =====
// ----------------------------------------------------------------------------
// dtc_front: item intake and frame maximum
// Applies clear and measure items to the maximum, queues classify items.
// ----------------------------------------------------------------------------
module dtc_front #(
   parameter int PIXEL_BITS = dtc_pkg::PIXEL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dtc_pkg::OPCODE_BITS-1:0]    req_opcode,
   input  logic [PIXEL_BITS-1:0]              req_pixel_value,
   input  logic                               q_full,
   output logic                               q_push,
   output logic [2*PIXEL_BITS-1:0]            q_push_data
);

   logic [PIXEL_BITS-1:0] max_ff;
   logic [PIXEL_BITS-1:0] max_in;
   logic                  accept;

   assign req_ready   = !q_full;
   assign accept      = req_valid && req_ready;
   assign q_push      = accept && (req_opcode == dtc_pkg::OP_CLASSIFY);
   // entry: pixel in the upper half, maximum snapshot in the lower half
   assign q_push_data = {req_pixel_value, max_ff};

   always_comb begin
      max_in = max_ff;
      if (accept) begin
         case (req_opcode)
            dtc_pkg::OP_CLEAR: begin
               max_in = '0;
            end
            dtc_pkg::OP_MEASURE: begin
               if (req_pixel_value > max_ff) begin
                  max_in = req_pixel_value;
               end
            end
            default: begin
               max_in = max_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
      end else begin
         max_ff <= max_in;
      end
   end

endmodule

// ===== design/dtc_queue.sv =====
// ----------------------------------------------------------------------------
// dtc_queue: short FIFO between front and back
// Register-based, first-word fall-through head.
// ----------------------------------------------------------------------------
module dtc_queue #(
   parameter int WIDTH = 2 * dtc_pkg::PIXEL_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0]                   mem_ff [dtc_pkg::Q_DEPTH];
   logic [dtc_pkg::Q_PTR_BITS-1:0]     wr_ptr_ff;
   logic [dtc_pkg::Q_PTR_BITS-1:0]     wr_ptr_in;
   logic [dtc_pkg::Q_PTR_BITS-1:0]     rd_ptr_ff;
   logic [dtc_pkg::Q_PTR_BITS-1:0]     rd_ptr_in;
   logic [dtc_pkg::Q_COUNT_BITS-1:0]   count_ff;
   logic [dtc_pkg::Q_COUNT_BITS-1:0]   count_in;

   assign head  = mem_ff[rd_ptr_ff];
   assign full  = (count_ff == dtc_pkg::Q_COUNT_BITS'(dtc_pkg::Q_DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/dtc_back.sv =====
// ----------------------------------------------------------------------------
// dtc_back: threshold arithmetic and result register
// Pop cycle forms max*ratio_high; compare cycle forms the low product,
// classifies and loads the result register.
// ----------------------------------------------------------------------------
module dtc_back #(
   parameter int PIXEL_BITS = dtc_pkg::PIXEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  logic [2*PIXEL_BITS-1:0]             q_head,
   output logic                                q_pop,
   input  logic [dtc_pkg::RATIO_BITS-1:0]      ratio_high,
   input  logic [dtc_pkg::RATIO_BITS-1:0]      ratio_low,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dtc_pkg::EDGE_BITS-1:0]       rsp_edge_value,
   output dtc_pkg::bk_status_type              status
);

   localparam int MH_BITS  = PIXEL_BITS + dtc_pkg::RATIO_BITS;
   localparam int LOW_BITS = MH_BITS + dtc_pkg::RATIO_BITS;

   dtc_pkg::bk_state_type state_ff;
   dtc_pkg::bk_state_type state_in;

   logic [PIXEL_BITS-1:0]             pix_ff;
   logic [MH_BITS-1:0]                mh_ff;
   logic [MH_BITS-1:0]                mh_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [dtc_pkg::EDGE_BITS-1:0]     edge_ff;
   logic [dtc_pkg::EDGE_BITS-1:0]     class_code;
   logic [LOW_BITS-1:0]               low_prod;
   logic [MH_BITS-1:0]                pix_hi;
   logic [LOW_BITS-1:0]               pix_lo;
   logic                              out_free;
   logic                              done;
   logic                              pop;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign done     = (state_ff == dtc_pkg::BK_CMP) && out_free;

   // high threshold compare is p*2^16 vs max*rh; low is p*2^32 vs max*rh*rl
   assign mh_in    = MH_BITS'(q_head[PIXEL_BITS-1:0]) * MH_BITS'(ratio_high);
   assign low_prod = LOW_BITS'(mh_ff) * LOW_BITS'(ratio_low);
   assign pix_hi   = MH_BITS'({pix_ff, {dtc_pkg::FRAC_BITS{1'b0}}});
   assign pix_lo   = LOW_BITS'({pix_ff, {(2 * dtc_pkg::FRAC_BITS){1'b0}}});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtc_pkg::BK_IDLE: begin
            if (!q_empty) begin
               state_in = dtc_pkg::BK_CMP;
            end
         end
         dtc_pkg::BK_CMP: begin
            if (done && q_empty) begin
               state_in = dtc_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = dtc_pkg::BK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      pop = 1'b0;
      case (state_ff)
         dtc_pkg::BK_IDLE: begin
            pop = !q_empty;
         end
         dtc_pkg::BK_CMP: begin
            pop = done && !q_empty;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (pix_hi > mh_ff) begin
         class_code = dtc_pkg::EDGE_STRONG;
      end else if ((pix_hi < mh_ff) && (pix_lo > low_prod)) begin
         class_code = dtc_pkg::EDGE_WEAK;
      end else begin
         class_code = dtc_pkg::EDGE_NONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtc_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mh_ff  <= mh_in;
         pix_ff <= q_head[2*PIXEL_BITS-1:PIXEL_BITS];
      end
      if (done) begin
         edge_ff <= class_code;
      end
   end

   assign q_pop          = pop;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_value = edge_ff;
   assign status.busy    = (state_ff == dtc_pkg::BK_CMP);
   assign status.pop     = pop;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the double threshold classifier
// A directed table walks the threshold edges and the opcodes. Random pixel
// frames then run under several ratio settings, each classify result checked
// against an exact integer model of the two thresholds.
// ----------------------------------------------------------------------------
module testbench;

   // opcode 3 and register index 3 are unused by the block
   localparam logic [dtc_pkg::OPCODE_BITS-1:0]    OP_SPARE  = 2'd3;
   localparam logic [dtc_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int DRAIN_CYCLES   = 8;
   localparam int ITEMS_PER_SET  = 48;

   typedef struct packed {
      logic [dtc_pkg::OPCODE_BITS-1:0] op;
      logic [7:0]                      pix;
      logic                            typed;     // edge_val holds the known answer
      logic [dtc_pkg::EDGE_BITS-1:0]   edge_val;
   } plan_row_type;

   typedef struct packed {
      logic [dtc_pkg::RATIO_BITS-1:0] hi;
      logic [dtc_pkg::RATIO_BITS-1:0] lo;
   } ratio_pair_type;

   localparam int PLAN_ROWS = 24;

   // Directed rows run at the reset ratios: high = max, low = max / 2.
   localparam plan_row_type PLAN [0:PLAN_ROWS-1] = '{
      '{dtc_pkg::OP_CLASSIFY, 8'd0,   1'b1, dtc_pkg::EDGE_NONE},    // max 0, pixel 0
      '{dtc_pkg::OP_CLASSIFY, 8'd255, 1'b1, dtc_pkg::EDGE_STRONG},  // max 0: nonzero is strong
      '{dtc_pkg::OP_MEASURE,  8'd200, 1'b0, dtc_pkg::EDGE_NONE},
      '{dtc_pkg::OP_CLASSIFY, 8'd200, 1'b1, dtc_pkg::EDGE_NONE},    // equal to high gives 0
      '{dtc_pkg::OP_CLASSIFY, 8'd201, 1'b1, dtc_pkg::EDGE_STRONG},
      '{dtc_pkg::OP_CLASSIFY, 8'd150, 1'b1, dtc_pkg::EDGE_WEAK},
      '{dtc_pkg::OP_CLASSIFY, 8'd100, 1'b1, dtc_pkg::EDGE_NONE},    // equal to low
      '{dtc_pkg::OP_CLASSIFY, 8'd101, 1'b1, dtc_pkg::EDGE_WEAK},
      '{dtc_pkg::OP_CLASSIFY, 8'd0,   1'b1, dtc_pkg::EDGE_NONE},
      '{OP_SPARE,             8'd255, 1'b0, dtc_pkg::EDGE_NONE},    // ignored, max stays 200
      '{dtc_pkg::OP_CLASSIFY, 8'd200, 1'b1, dtc_pkg::EDGE_NONE},
      '{dtc_pkg::OP_MEASURE,  8'd100, 1'b0, dtc_pkg::EDGE_NONE},    // smaller, no change
      '{dtc_pkg::OP_MEASURE,  8'd255, 1'b0, dtc_pkg::EDGE_NONE},
      '{dtc_pkg::OP_CLASSIFY, 8'd255, 1'b1, dtc_pkg::EDGE_NONE},
      '{dtc_pkg::OP_CLASSIFY, 8'd128, 1'b0, dtc_pkg::EDGE_NONE},    // just above the half step
      '{dtc_pkg::OP_CLASSIFY, 8'd127, 1'b0, dtc_pkg::EDGE_NONE},
      '{dtc_pkg::OP_CLEAR,    8'hAA,  1'b0, dtc_pkg::EDGE_NONE},    // pixel ignored on clear
      '{dtc_pkg::OP_CLASSIFY, 8'd1,   1'b1, dtc_pkg::EDGE_STRONG},
      '{dtc_pkg::OP_MEASURE,  8'd1,   1'b0, dtc_pkg::EDGE_NONE},
      '{dtc_pkg::OP_CLASSIFY, 8'd1,   1'b1, dtc_pkg::EDGE_NONE},
      '{OP_SPARE,             8'd0,   1'b0, dtc_pkg::EDGE_NONE},
      '{dtc_pkg::OP_CLEAR,    8'hFF,  1'b0, dtc_pkg::EDGE_NONE},
      '{dtc_pkg::OP_MEASURE,  8'd0,   1'b0, dtc_pkg::EDGE_NONE},
      '{dtc_pkg::OP_CLASSIFY, 8'd0,   1'b1, dtc_pkg::EDGE_NONE}
   };

   localparam int RATIO_SETS = 9;
   localparam logic [dtc_pkg::RATIO_BITS-1:0] RATIO_ALL = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               csr_wr_en   = 1'b0;
   logic [dtc_pkg::CSR_INDEX_BITS-1:0] csr_index   = dtc_pkg::CSR_RATIO_HIGH;
   logic [dtc_pkg::RATIO_BITS-1:0]     csr_wr_data = '0;

   logic                               req_valid       = 1'b0;
   logic                               req_ready;
   logic [dtc_pkg::OPCODE_BITS-1:0]    req_opcode      = dtc_pkg::OP_CLEAR;
   logic [7:0]                         req_pixel_value = '0;

   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [dtc_pkg::EDGE_BITS-1:0]      rsp_edge_value;

   // model state
   logic [7:0]                     max_level;
   logic [dtc_pkg::RATIO_BITS-1:0] ratio_hi;
   logic [dtc_pkg::RATIO_BITS-1:0] ratio_lo;

   logic [dtc_pkg::EDGE_BITS-1:0]  pending_edges [$];

   int fail_count   = 0;
   int real_items   = 0;
   int spare_items  = 0;
   int n_strong     = 0;
   int n_weak       = 0;
   int n_none       = 0;
   int send_idle    = 9;    // percent of cycles the sender holds back
   int take_idle    = 60;   // percent of cycles the receiver stalls

   double_threshold_classifier i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_edge_value  (rsp_edge_value)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Exact compare, no rounding: pixel * 2^32 against max * rh * 2^16
   // (high) and max * rh * rl (low). Everything stays under 2^50.
   function automatic logic [dtc_pkg::EDGE_BITS-1:0] grade_pixel(input logic [7:0] pix);
      logic [63:0] scaled;
      logic [63:0] prod;
      logic [63:0] hi_s;
      logic [63:0] lo_s;
      scaled = 64'(pix) << 32;
      prod   = 64'(max_level) * 64'(ratio_hi);
      hi_s   = prod << 16;
      lo_s   = prod * 64'(ratio_lo);
      if (scaled > hi_s)
         return dtc_pkg::EDGE_STRONG;
      if (scaled < hi_s && scaled > lo_s)
         return dtc_pkg::EDGE_WEAK;
      return dtc_pkg::EDGE_NONE;
   endfunction

   // Present one item, hold it until taken, then advance the model.
   // Valid drops between items only for the random idle cycles.
   task automatic send_item(input logic [dtc_pkg::OPCODE_BITS-1:0] op,
                            input logic [7:0] pix,
                            input logic typed,
                            input logic [dtc_pkg::EDGE_BITS-1:0] typed_edge);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_pixel_value <= pix;
      do @(posedge clock); while (!req_ready);
      case (op)
         dtc_pkg::OP_CLEAR: max_level = '0;
         dtc_pkg::OP_MEASURE: begin
            if (pix > max_level)
               max_level = pix;
         end
         dtc_pkg::OP_CLASSIFY:
            pending_edges.push_back(typed ? typed_edge : grade_pixel(pix));
         default: ;
      endcase
      if (op == OP_SPARE)
         spare_items++;
      else
         real_items++;
   endtask

   // Let every result out, then give the back end time to settle.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_edges.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Both ratios, then a write to an unused index that must change nothing.
   task automatic set_ratios(input logic [dtc_pkg::RATIO_BITS-1:0] hi,
                             input logic [dtc_pkg::RATIO_BITS-1:0] lo);
      drain();
      csr_wr_en   <= 1'b1;
      csr_index   <= dtc_pkg::CSR_RATIO_HIGH;
      csr_wr_data <= hi;
      @(posedge clock);
      csr_index   <= dtc_pkg::CSR_RATIO_LOW;
      csr_wr_data <= lo;
      @(posedge clock);
      csr_index   <= CSR_SPARE;
      csr_wr_data <= dtc_pkg::RATIO_BITS'($urandom);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ratio_hi = hi;
      ratio_lo = lo;
   endtask

   // Receiver: random stalls, and every taken item checked in order.
   always @(posedge clock) begin
      logic [dtc_pkg::EDGE_BITS-1:0] want;
      rsp_ready <= ($urandom_range(99) >= take_idle);
      if (!reset && rsp_valid && rsp_ready) begin
         case (rsp_edge_value)
            dtc_pkg::EDGE_STRONG: n_strong++;
            dtc_pkg::EDGE_WEAK:   n_weak++;
            default:              n_none++;
         endcase
         if (pending_edges.size() == 0) begin
            $display("%0t: result %0d with nothing expected", $time, rsp_edge_value);
            fail_count++;
         end else begin
            want = pending_edges.pop_front();
            if (rsp_edge_value !== want) begin
               $display("%0t: edge_value mismatch, expected %0d, got %0d",
                        $time, want, rsp_edge_value);
               fail_count++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      ratio_pair_type                  sets [RATIO_SETS];
      int                              quota;
      int                              n_meas;
      int                              n_cls;
      int                              cand;
      logic [63:0]                     hi_int;
      logic [63:0]                     lo_int;
      logic [dtc_pkg::OPCODE_BITS-1:0] op;

      max_level = '0;
      ratio_hi  = dtc_pkg::RATIO_HIGH_RESET;
      ratio_lo  = dtc_pkg::RATIO_LOW_RESET;

      // reset values first, then the corners: zero, all ones, low equal to
      // high (nothing can be weak), each ratio alone at an extreme, one mixed pair, two random
      sets[0] = '{dtc_pkg::RATIO_HIGH_RESET, dtc_pkg::RATIO_LOW_RESET};
      sets[1] = '{'0, '0};
      sets[2] = '{RATIO_ALL, RATIO_ALL};
      sets[3] = '{17'd65536, 17'd65536};
      sets[4] = '{RATIO_ALL, '0};
      sets[5] = '{'0, RATIO_ALL};
      sets[6] = '{17'd49152, 17'd81920};
      sets[7] = '{dtc_pkg::RATIO_BITS'($urandom_range(131071)),
                  dtc_pkg::RATIO_BITS'($urandom_range(65536))};
      sets[8] = '{dtc_pkg::RATIO_BITS'($urandom_range(131071)),
                  dtc_pkg::RATIO_BITS'($urandom_range(131071))};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++)
         send_item(PLAN[r].op, PLAN[r].pix, PLAN[r].typed, PLAN[r].edge_val);

      for (int s = 0; s < RATIO_SETS; s++) begin
         set_ratios(sets[s].hi, sets[s].lo);
         quota = real_items + ITEMS_PER_SET;
         while (real_items < quota) begin
            // sender-light / receiver-heavy, then the reverse, then flat out
            if (real_items < 190) begin
               send_idle = 9;
               take_idle = 60;
            end else if (real_items < 360) begin
               send_idle = 60;
               take_idle = 9;
            end else begin
               send_idle = 0;
               take_idle = 0;
            end
            if ($urandom_range(99) < 80) begin
               // one frame: clear, measure pass, classify pass
               send_item(dtc_pkg::OP_CLEAR, 8'($urandom), 1'b0, dtc_pkg::EDGE_NONE);
               n_meas = $urandom_range(1, 6);
               for (int k = 0; k < n_meas; k++)
                  send_item(dtc_pkg::OP_MEASURE,
                            ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom),
                            1'b0, dtc_pkg::EDGE_NONE);
               n_cls = $urandom_range(1, 8);
               for (int k = 0; k < n_cls; k++) begin
                  // aim most pixels at one step around either threshold
                  hi_int = (64'(max_level) * 64'(ratio_hi)) >> 16;
                  lo_int = (64'(max_level) * 64'(ratio_hi) * 64'(ratio_lo)) >> 32;
                  if ($urandom_range(9) < 6) begin
                     cand = int'($urandom_range(1) ? hi_int : lo_int)
                            + int'($urandom_range(2)) - 1;
                     if (cand < 0)
                        cand = 0;
                     if (cand > 255)
                        cand = 255;
                  end else begin
                     cand = int'($urandom_range(255));
                  end
                  send_item(dtc_pkg::OP_CLASSIFY, 8'(cand), 1'b0, dtc_pkg::EDGE_NONE);
               end
            end else begin
               // loose item, any opcode including the unused one
               op = dtc_pkg::OPCODE_BITS'($urandom_range(3));
               send_item(op, 8'($urandom), 1'b0, dtc_pkg::EDGE_NONE);
            end
         end
      end

      drain();

      $display("Ran %0d items plus %0d unused-opcode items over %0d ratio settings.",
               real_items, spare_items, RATIO_SETS);
      $display("Edge results seen: %0d strong, %0d weak, %0d suppressed.",
               n_strong, n_weak, n_none);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #3000000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== double_threshold_classifier.f =====
design/dtc_pkg.sv
design/dtc_front.sv
design/dtc_queue.sv
design/dtc_back.sv
design/double_threshold_classifier.sv
test/testbench.sv
